FILE: design/hsv_to_rgb_converter_unit_macros.svh
// Assertion macros shared by the HSV to RGB converter modules.
// Needs a clk_i clock and an rst_ni active-low reset in the using module.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while the block is out of reset.
`define HSVRGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define HSVRGB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define HSVRGB_ASSERT(lbl, prop, msg)
`define HSVRGB_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: design/hsvrgb_pkg.sv
// Shared types and constants of the HSV to RGB converter.
// Used by every module of the converter; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hsvrgb_pkg;

  // Number of register stages, the output register included.
  localparam int STAGES = 8;

  // Hue is in sixteenths of a degree; a full turn and one sector.
  localparam int HUE_W = 16;
  localparam int HUE_X_W = 17;
  // Six full turns, so that any 16-bit signed hue becomes positive.
  localparam logic [HUE_X_W-1:0] HUE_BIAS = 17'd34560;

  // A sector of 960 is 64 times 15.
  localparam int SEC_SHIFT = 6;
  localparam int SEC_Y_W = HUE_X_W - SEC_SHIFT;
  localparam logic [3:0] SEC_ODD = 4'd15;

  // Reciprocal of 15 for the coarse quotient, 136 / 2048.
  localparam logic [7:0] Y_RECIP = 8'd136;
  localparam int Y_RECIP_SHIFT = 11;

  // Reciprocal of 6 for folding the turn count, 21 / 128.
  localparam logic [4:0] SIX_RECIP = 5'd21;
  localparam int SIX_RECIP_SHIFT = 7;
  localparam logic [2:0] NUM_SECTORS = 3'd6;

  localparam int TURN_W = 7;
  localparam int REM_W = 10;
  localparam int OUT_W = 13;

  // Sector codes, named by the hues they span.
  localparam logic [2:0] SEC_RY = 3'd0;
  localparam logic [2:0] SEC_YG = 3'd1;
  localparam logic [2:0] SEC_GC = 3'd2;
  localparam logic [2:0] SEC_CB = 3'd3;
  localparam logic [2:0] SEC_BM = 3'd4;
  localparam logic [2:0] SEC_MR = 3'd5;

  // Per-stage load enables and valid bits from the pipeline control.
  typedef struct packed {
    logic [STAGES-1:0] en;
    logic [STAGES-1:0] vld;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

FILE: design/hsvrgb_ctrl.sv
// Valid and load-enable chain of the converter pipeline.
// Depends on hsvrgb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb_converter_unit_macros.svh"

module hsvrgb_ctrl import hsvrgb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output pipe_ctrl_t      ctrl_o
);

  logic [STAGES-1:0] vld_q;
  logic [STAGES-1:0] vld_d;
  logic [STAGES-1:0] en;

  // A stage loads when it is empty or when the stage after it loads,
  // so bubbles are squeezed out while the output is stalled.
  always_comb begin
    en[STAGES-1] = !vld_q[STAGES-1] || !out_stall_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < STAGES; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[STAGES-1];
  assign ctrl_o      = '{en: en, vld: vld_q};

  `HSVRGB_ASSERT(a_stall_only_when_full, in_stall_o |-> (&vld_q), "input stalled with a bubble")
  `HSVRGB_ASSERT(a_count_grows, (in_valid_i && !in_stall_o && !(out_valid_o && !out_stall_i)) |=> ($countones(vld_q) == $past($countones(vld_q)) + 1), "request lost in pipeline")
  `HSVRGB_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (vld_q == '0), "pipeline not empty in reset")

endmodule

`default_nettype wire

FILE: design/hsvrgb_hue.sv
// Hue path: wraps the hue, finds the sector and the fraction within it.
// Depends on hsvrgb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb_converter_unit_macros.svh"

module hsvrgb_hue import hsvrgb_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire pipe_ctrl_t               ctrl_i,
  input  wire logic signed [HUE_W-1:0]  hue_i,
  output logic             [2:0]        sector_o,
  output logic             [FRAC_BITS:0] frac_o
);

  localparam int W  = FRAC_BITS + 1;
  localparam int NW = FRAC_BITS + 4;
  localparam int PW = NW + W;
  localparam int MF = (2 ** NW) / 15;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Stage 0: biased hue.
  logic [HUE_X_W-1:0] x0_q;
  // Stage 1: raw coarse quotient.
  logic [HUE_X_W-1:0] x1_q;
  logic [TURN_W-1:0]  qyr_q;
  // Stage 2: turn count and offset inside the sector.
  logic [TURN_W-1:0]  qy2_q;
  logic [REM_W-1:0]   rem2_q;
  // Stage 3: raw quotients by 6 and by 15.
  logic [TURN_W-1:0]  qy3_q;
  logic [3:0]         q6r_q;
  logic [REM_W-1:0]   rem3_q;
  logic [W-1:0]       fraw_q;
  // Stage 4: results.
  logic [2:0]         sector_q;
  logic [W-1:0]       frac_q;

  logic [SEC_Y_W-1:0]   y1;
  logic [SEC_Y_W+7:0]   yprod;
  logic [SEC_Y_W-1:0]   y2;
  logic [SEC_Y_W-1:0]   ry_full;
  logic [4:0]           ry;
  logic [TURN_W-1:0]    qy_fix;
  logic [3:0]           ry_fix;
  logic [NW-1:0]        n3;
  logic [PW-1:0]        fprod;
  logic [TURN_W+4:0]    q6prod;
  logic [TURN_W-1:0]    r6_full;
  logic [3:0]           r6;
  logic [2:0]           sector_d;
  logic [NW-1:0]        n4;
  logic [NW-1:0]        rf_full;
  logic [4:0]           rf;
  logic [W-1:0]         frac_d;

  always_comb begin
    y1    = x0_q[HUE_X_W-1:SEC_SHIFT];
    yprod = (SEC_Y_W + 8)'(y1) * (SEC_Y_W + 8)'(Y_RECIP);

    // The raw quotient is at most one short; one correction step.
    y2      = x1_q[HUE_X_W-1:SEC_SHIFT];
    ry_full = y2 - SEC_Y_W'(qyr_q) * SEC_Y_W'(SEC_ODD);
    ry      = ry_full[4:0];
    if (ry >= 5'(SEC_ODD)) begin
      qy_fix = qyr_q + TURN_W'(1);
      ry_fix = 4'(ry - 5'(SEC_ODD));
    end else begin
      qy_fix = qyr_q;
      ry_fix = ry[3:0];
    end

    // f = rem * 2^FRAC_BITS / 960 = (rem << (FRAC_BITS - 6)) / 15.
    n3     = NW'(rem2_q) << (FRAC_BITS - SEC_SHIFT);
    fprod  = PW'(n3) * PW'(MF);
    q6prod = (TURN_W + 5)'(qy2_q) * (TURN_W + 5)'(SIX_RECIP);

    r6_full = qy3_q - TURN_W'(q6r_q) * TURN_W'(NUM_SECTORS);
    r6      = r6_full[3:0];
    if (r6 >= 4'(NUM_SECTORS)) begin
      sector_d = 3'(r6 - 4'(NUM_SECTORS));
    end else begin
      sector_d = r6[2:0];
    end

    n4      = NW'(rem3_q) << (FRAC_BITS - SEC_SHIFT);
    rf_full = n4 - NW'(fraw_q) * NW'(SEC_ODD);
    rf      = rf_full[4:0];
    if (rf >= 5'(SEC_ODD)) begin
      frac_d = fraw_q + W'(1);
    end else begin
      frac_d = fraw_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      x0_q <= {hue_i[HUE_W-1], hue_i} + HUE_BIAS;
    end
    if (ctrl_i.en[1]) begin
      x1_q  <= x0_q;
      qyr_q <= yprod[Y_RECIP_SHIFT +: TURN_W];
    end
    if (ctrl_i.en[2]) begin
      qy2_q  <= qy_fix;
      rem2_q <= {ry_fix, x1_q[SEC_SHIFT-1:0]};
    end
    if (ctrl_i.en[3]) begin
      qy3_q  <= qy2_q;
      q6r_q  <= q6prod[SIX_RECIP_SHIFT +: 4];
      rem3_q <= rem2_q;
      fraw_q <= fprod[NW +: W];
    end
    if (ctrl_i.en[4]) begin
      sector_q <= sector_d;
      frac_q   <= frac_d;
    end
  end

  assign sector_o = sector_q;
  assign frac_o   = frac_q;

  `HSVRGB_ASSERT(a_sector_range, ctrl_i.vld[4] |-> (sector_q < NUM_SECTORS), "sector out of range")
  `HSVRGB_ASSERT(a_frac_below_one, ctrl_i.vld[4] |-> (frac_q < ONE), "fraction reached one")

endmodule

`default_nettype wire

FILE: design/hsvrgb_mix.sv
// Color path: clamps s and v, forms p, q and t, selects r, g and b.
// Depends on hsvrgb_pkg, the hue path results and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb_converter_unit_macros.svh"

module hsvrgb_mix import hsvrgb_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire pipe_ctrl_t                ctrl_i,
  input  wire logic signed [HUE_W-1:0]   saturation_i,
  input  wire logic signed [HUE_W-1:0]   brightness_i,
  input  wire logic        [2:0]         sector_i,
  input  wire logic        [FRAC_BITS:0] frac_i,
  output logic             [OUT_W-1:0]   red_o,
  output logic             [OUT_W-1:0]   green_o,
  output logic             [OUT_W-1:0]   blue_o
);

  localparam int W  = FRAC_BITS + 1;
  localparam int PW = 2 * W;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [W-1:0] s_q  [0:4];
  logic [W-1:0] v_q  [0:6];
  logic [W-1:0] p_q  [1:6];
  logic         sz_q [0:6];
  logic [2:0]   sec_q [5:6];
  logic [W-1:0] sf_q;
  logic [W-1:0] s1f_q;
  logic [W-1:0] qq_q;
  logic [W-1:0] tt_q;
  logic [OUT_W-1:0] red_q;
  logic [OUT_W-1:0] green_q;
  logic [OUT_W-1:0] blue_q;

  logic [W-1:0]  s_clamp;
  logic [W-1:0]  v_clamp;
  logic [PW-1:0] p_prod;
  logic [PW-1:0] sf_prod;
  logic [PW-1:0] s1f_prod;
  logic [PW-1:0] q_prod;
  logic [PW-1:0] t_prod;
  logic [W-1:0]  r_sel;
  logic [W-1:0]  g_sel;
  logic [W-1:0]  b_sel;

  // Negative values read as zero, values above one as one.
  function automatic logic [W-1:0] clamp_unit(input logic signed [HUE_W-1:0] x);
    logic [HUE_W-2:0] mag;
    mag = x[HUE_W-2:0];
    if (x[HUE_W-1]) begin
      return '0;
    end else if (32'(mag) > 32'(ONE)) begin
      return ONE;
    end else begin
      return W'(mag);
    end
  endfunction

  always_comb begin
    s_clamp  = clamp_unit(saturation_i);
    v_clamp  = clamp_unit(brightness_i);
    p_prod   = PW'(v_q[0]) * PW'(ONE - s_q[0]);
    sf_prod  = PW'(s_q[4]) * PW'(frac_i);
    s1f_prod = PW'(s_q[4]) * PW'(ONE - frac_i);
    q_prod   = PW'(v_q[5]) * PW'(ONE - sf_q);
    t_prod   = PW'(v_q[5]) * PW'(ONE - s1f_q);
  end

  always_comb begin
    if (sz_q[6]) begin
      r_sel = v_q[6];
      g_sel = v_q[6];
      b_sel = v_q[6];
    end else begin
      unique case (sec_q[6])
        SEC_RY: begin
          r_sel = v_q[6];
          g_sel = tt_q;
          b_sel = p_q[6];
        end
        SEC_YG: begin
          r_sel = qq_q;
          g_sel = v_q[6];
          b_sel = p_q[6];
        end
        SEC_GC: begin
          r_sel = p_q[6];
          g_sel = v_q[6];
          b_sel = tt_q;
        end
        SEC_CB: begin
          r_sel = p_q[6];
          g_sel = qq_q;
          b_sel = v_q[6];
        end
        SEC_BM: begin
          r_sel = tt_q;
          g_sel = p_q[6];
          b_sel = v_q[6];
        end
        default: begin
          r_sel = v_q[6];
          g_sel = p_q[6];
          b_sel = qq_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      s_q[0]  <= s_clamp;
      v_q[0]  <= v_clamp;
      sz_q[0] <= (s_clamp == '0);
    end
    for (int k = 1; k <= 4; k++) begin
      if (ctrl_i.en[k]) begin
        s_q[k] <= s_q[k-1];
      end
    end
    for (int k = 1; k <= 6; k++) begin
      if (ctrl_i.en[k]) begin
        v_q[k]  <= v_q[k-1];
        sz_q[k] <= sz_q[k-1];
      end
    end
    if (ctrl_i.en[1]) begin
      p_q[1] <= p_prod[FRAC_BITS +: W];
    end
    for (int k = 2; k <= 6; k++) begin
      if (ctrl_i.en[k]) begin
        p_q[k] <= p_q[k-1];
      end
    end
    if (ctrl_i.en[5]) begin
      sec_q[5] <= sector_i;
      sf_q     <= sf_prod[FRAC_BITS +: W];
      s1f_q    <= s1f_prod[FRAC_BITS +: W];
    end
    if (ctrl_i.en[6]) begin
      sec_q[6] <= sec_q[5];
      qq_q     <= q_prod[FRAC_BITS +: W];
      tt_q     <= t_prod[FRAC_BITS +: W];
    end
    if (ctrl_i.en[7]) begin
      red_q   <= OUT_W'(r_sel);
      green_q <= OUT_W'(g_sel);
      blue_q  <= OUT_W'(b_sel);
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  `HSVRGB_ASSERT(a_gray_equal, (ctrl_i.vld[6] && ctrl_i.en[7] && sz_q[6]) |=> ((red_o == green_o) && (green_o == blue_o)), "gray request gave unequal channels")

endmodule

`default_nettype wire

FILE: design/hsv_to_rgb_converter_unit.sv
// Channel   Direction  Handshake                 Payload
// request   in         in_valid_i / in_stall_o   hue_i, saturation_i, brightness_i
// result    out        out_valid_o / out_stall_i red_o, green_o, blue_o
//
// One request enters per clock while the input is not stalled; each result
// passes through the eight register stages of the hue and color paths.
// Reset clears only the stage valid bits, so the pipeline comes up empty.
// A stalled output holds its stage; earlier stages keep filling bubbles,
// and the input stalls only once every stage holds a request.
//
// Top level of the HSV to RGB converter. Depends on hsvrgb_pkg,
// hsvrgb_ctrl, hsvrgb_hue and hsvrgb_mix.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter_unit import hsvrgb_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [HUE_W-1:0]  hue_i,
  input  wire logic signed [HUE_W-1:0]  saturation_i,
  input  wire logic signed [HUE_W-1:0]  brightness_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic             [OUT_W-1:0]  red_o,
  output logic             [OUT_W-1:0]  green_o,
  output logic             [OUT_W-1:0]  blue_o
);

  // Stage plan, one register per stage:
  //   0: hue biased by six turns so it is positive; s and v clamped.
  //   1: coarse hue quotient by reciprocal multiply; p = v(1-s).
  //   2: quotient corrected, giving turn count and offset in the sector.
  //   3: turn count folded by six and offset scaled by 1/15 (raw).
  //   4: sector and fraction f corrected.
  //   5: s*f and s*(1-f).
  //   6: q = v(1-sf) and t = v(1-s(1-f)).
  //   7: per-sector selection into the output register.
  pipe_ctrl_t           ctrl;
  logic [2:0]           sector;
  logic [FRAC_BITS:0]   frac;

  hsvrgb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  // The hue path delivers sector and fraction at the end of stage four,
  // in step with the saturation and value carried by the color path.
  hsvrgb_hue #(
    .FRAC_BITS (FRAC_BITS)
  ) u_hue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .hue_i    (hue_i),
    .sector_o (sector),
    .frac_o   (frac)
  );

  hsvrgb_mix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .sector_i     (sector),
    .frac_i       (frac),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

endmodule

`default_nettype wire
